// File: src/assert_macros.svh
// Assertion macros for the RTL, used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset
`define SOBT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent in the same cycle as the antecedent
`define SOBT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent
`define SOBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sobt_pkg.sv
// Package: types, codes and sizes for the sorted override bit table
package sobt_pkg;

    localparam int SOBT_MAX_ENTRIES = 64;

    localparam int ACTION_W      = 2;
    localparam int ITEM_ID_W     = 16;
    localparam int ENTRY_INDEX_W = 6;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 7;

    localparam logic [ACTION_W-1:0] ACT_TOGGLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_SET
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_APPLY
    } state_t;

    // per-cell flags and read data handed to the top level
    typedef struct packed {
        logic                 lt;
        logic                 eq;
        logic                 eq_bit;
        logic                 rd_hit;
        logic                 rd_bit;
        logic [ITEM_ID_W-1:0] rd_id;
    } cell_stat_t;

endpackage

// File: src/sobt_cell.sv
// One table position: id, override bit, compare flags and shift path
module sobt_cell
    import sobt_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
)
(
    input  logic                     clk,
    input  logic                     capture,
    input  cell_op_t                 op,
    input  logic [ITEM_ID_W-1:0]     key,
    input  logic                     new_bit,
    input  logic [CNT_W-1:0]         count,
    input  logic [ENTRY_INDEX_W-1:0] req_index,
    input  logic [ITEM_ID_W-1:0]     prev_id,
    input  logic                     prev_bit,
    input  logic                     prev_lt,
    input  logic [ITEM_ID_W-1:0]     next_id,
    input  logic                     next_bit,
    output logic [ITEM_ID_W-1:0]     id,
    output logic                     bit_val,
    output cell_stat_t               stat
);

    localparam bit                     IDX_REACH = IDX < (2 ** ENTRY_INDEX_W);
    localparam logic [ENTRY_INDEX_W-1:0] IDX_LO  = ENTRY_INDEX_W'(IDX);
    localparam logic [CNT_W-1:0]       IDX_CNT   = CNT_W'(IDX);

    logic [ITEM_ID_W-1:0] id_reg, id_next;
    logic                 bit_reg, bit_next;
    logic                 lt_reg, eq_reg, rd_hit_reg;
    logic                 used;

    assign used = count > IDX_CNT;

    always_comb
    begin
        id_next  = id_reg;
        bit_next = bit_reg;
        unique case (op)
            OP_INSERT:
            begin
                if (!lt_reg)
                begin
                    id_next  = prev_lt ? key : prev_id;
                    bit_next = prev_lt ? new_bit : prev_bit;
                end
            end
            OP_DELETE:
            begin
                if (!lt_reg)
                begin
                    id_next  = next_id;
                    bit_next = next_bit;
                end
            end
            OP_SET:
            begin
                if (eq_reg)
                    bit_next = new_bit;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        bit_reg <= bit_next;
        if (capture)
        begin
            lt_reg     <= used && (id_reg < key);
            eq_reg     <= used && (id_reg == key);
            rd_hit_reg <= used && IDX_REACH && (req_index == IDX_LO);
        end
    end

    assign id      = id_reg;
    assign bit_val = bit_reg;

    assign stat.lt     = lt_reg;
    assign stat.eq     = eq_reg;
    assign stat.eq_bit = eq_reg & bit_reg;
    assign stat.rd_hit = rd_hit_reg;
    assign stat.rd_bit = rd_hit_reg & bit_reg;
    assign stat.rd_id  = rd_hit_reg ? id_reg : '0;

endmodule

// File: src/sorted_override_bit_table_top.sv
// Top level: request control, cell row and result register
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid, in_stall  | action, item_id, document_checked, entry_index
//  out     | out_valid, out_stall| status, checked, entry_item_id, entry_count
//
// Each request steps through accept, compare in every cell, reduce the
// cell flags, then shift or update the row and load the result register.
// A new request is taken once control is back in idle, even while a result waits.
// The apply step holds while the result register is full and stalled.
// Reset empties the table; the cell storage itself is not cleared.
`include "assert_macros.svh"

module sorted_override_bit_table_top
    import sobt_pkg::*;
#(
    parameter int MAX_ENTRIES = SOBT_MAX_ENTRIES
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ACTION_W-1:0]      action,
    input  logic [ITEM_ID_W-1:0]     item_id,
    input  logic                     document_checked,
    input  logic [ENTRY_INDEX_W-1:0] entry_index,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic                     checked,
    output logic [ITEM_ID_W-1:0]     entry_item_id,
    output logic [ENTRY_COUNT_W-1:0] entry_count
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;

    logic [ACTION_W-1:0]      act_reg;
    logic [ITEM_ID_W-1:0]     key_reg;
    logic                     doc_reg;
    logic [ENTRY_INDEX_W-1:0] idx_reg;

    logic                 present_reg, hit_bit_reg, rd_ok_reg, rd_bit_reg;
    logic [ITEM_ID_W-1:0] rd_id_reg;

    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic                     checked_reg, checked_next;
    logic [ITEM_ID_W-1:0]     rid_reg, rid_next;

    logic       in_take;
    logic       out_free;
    logic       capture;
    logic       load_out;
    cell_op_t   op;
    logic       before_bit, after_bit;

    logic [ITEM_ID_W-1:0] ids  [MAX_ENTRIES];
    logic                 bits [MAX_ENTRIES];
    cell_stat_t           stats[MAX_ENTRIES];

    logic                 any_eq, any_eq_bit, any_rd, any_rd_bit;
    logic [ITEM_ID_W-1:0] any_rd_id;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // cell row
    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        logic [ITEM_ID_W-1:0] prev_id, next_id;
        logic                 prev_bit, prev_lt, next_bit;

        if (g == 0)
        begin : g_first
            assign prev_id  = key_reg;
            assign prev_bit = after_bit;
            assign prev_lt  = 1'b1;
        end
        else
        begin : g_inner
            assign prev_id  = ids[g-1];
            assign prev_bit = bits[g-1];
            assign prev_lt  = stats[g-1].lt;
        end

        if (g == MAX_ENTRIES - 1)
        begin : g_last
            assign next_id  = ids[g];
            assign next_bit = bits[g];
        end
        else
        begin : g_body
            assign next_id  = ids[g+1];
            assign next_bit = bits[g+1];
        end

        sobt_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .capture   (capture),
            .op        (op),
            .key       (key_reg),
            .new_bit   (after_bit),
            .count     (count_reg),
            .req_index (idx_reg),
            .prev_id   (prev_id),
            .prev_bit  (prev_bit),
            .prev_lt   (prev_lt),
            .next_id   (next_id),
            .next_bit  (next_bit),
            .id        (ids[g]),
            .bit_val   (bits[g]),
            .stat      (stats[g])
        );
    end

    // flag reduction over the row (registered in S_RED)
    always_comb
    begin
        any_eq     = 1'b0;
        any_eq_bit = 1'b0;
        any_rd     = 1'b0;
        any_rd_bit = 1'b0;
        any_rd_id  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            any_eq     = any_eq     | stats[i].eq;
            any_eq_bit = any_eq_bit | stats[i].eq_bit;
            any_rd     = any_rd     | stats[i].rd_hit;
            any_rd_bit = any_rd_bit | stats[i].rd_bit;
            any_rd_id  = any_rd_id  | stats[i].rd_id;
        end
    end

    assign before_bit = present_reg ? hit_bit_reg : doc_reg;
    assign after_bit  = ~before_bit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_take) state_next = S_CMP;
            S_CMP:   state_next = S_RED;
            S_RED:   state_next = S_APPLY;
            S_APPLY: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the control
    always_comb
    begin
        capture      = (state_reg == S_CMP);
        load_out     = (state_reg == S_APPLY) && out_free;
        op           = OP_NONE;
        count_next   = count_reg;
        status_next  = STATUS_OK;
        checked_next = 1'b0;
        rid_next     = '0;
        if (load_out)
        begin
            unique case (act_reg)
                ACT_TOGGLE:
                begin
                    if (after_bit == doc_reg)
                    begin
                        checked_next = after_bit;
                        if (present_reg)
                        begin
                            op         = OP_DELETE;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    else if (present_reg)
                    begin
                        op           = OP_SET;
                        checked_next = after_bit;
                    end
                    else if (count_reg >= CNT_MAX)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        op           = OP_INSERT;
                        count_next   = count_reg + CNT_W'(1);
                        checked_next = after_bit;
                    end
                end
                ACT_LOOKUP:
                begin
                    checked_next = before_bit;
                end
                ACT_READ:
                begin
                    if (rd_ok_reg)
                    begin
                        checked_next = rd_bit_reg;
                        rid_next     = rd_id_reg;
                    end
                    else
                    begin
                        status_next = STATUS_RANGE;
                    end
                end
                ACT_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            act_reg <= action;
            key_reg <= item_id;
            doc_reg <= document_checked;
            idx_reg <= entry_index;
        end
        if (state_reg == S_RED)
        begin
            present_reg <= any_eq;
            hit_bit_reg <= any_eq_bit;
            rd_ok_reg   <= any_rd;
            rd_bit_reg  <= any_rd_bit;
            rd_id_reg   <= any_rd_id;
        end
        if (load_out)
        begin
            status_reg  <= status_next;
            checked_reg <= checked_next;
            rid_reg     <= rid_next;
        end
    end

    logic [ENTRY_COUNT_W-1:0] count_out_reg;

    always_ff @(posedge clk)
    begin
        if (load_out)
            count_out_reg <= ENTRY_COUNT_W'(count_next);
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign checked       = checked_reg;
    assign entry_item_id = rid_reg;
    assign entry_count   = count_out_reg;

    `SOBT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_MAX,
        "entry count above table size")
    `SOBT_ASSERT_NEXT(a_take_to_cmp, clk, rst_n, in_take, state_reg == S_CMP,
        "accepted request did not start compare")
    `SOBT_ASSERT_SAME(a_result_from_apply, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == S_APPLY, "result appeared outside apply step")
    `SOBT_ASSERT_NEXT(a_count_hold, clk, rst_n, state_reg != S_APPLY, $stable(count_reg),
        "entry count changed outside apply step")

endmodule

// File: tb/sv/sobt_checker.sv
// Checker for the sorted override bit table: request predictor and result scoreboard
`timescale 1ns / 1ps

module sobt_checker
    import sobt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [ACTION_W-1:0]      action,
    input  logic [ITEM_ID_W-1:0]     item_id,
    input  logic                     document_checked,
    input  logic [ENTRY_INDEX_W-1:0] entry_index,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [STATUS_W-1:0]      status,
    input  logic                     checked,
    input  logic [ITEM_ID_W-1:0]     entry_item_id,
    input  logic [ENTRY_COUNT_W-1:0] entry_count,
    output int                       fail_count,
    output int                       pending,
    output int                       results_seen,
    output int                       full_refusals,
    output int                       erasures,
    output int                       range_reads
);

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     checked;
        logic [ITEM_ID_W-1:0]     entry_item_id;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } entry_result_t;

    logic [ITEM_ID_W-1:0] entry_ids  [SOBT_MAX_ENTRIES];
    logic                 entry_bits [SOBT_MAX_ENTRIES];
    int unsigned          used_entries = 0;
    entry_result_t        awaited_results [$];

    int mismatches = 0;
    int n_results  = 0;
    int n_full     = 0;
    int n_erased   = 0;
    int n_range    = 0;

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        if (mismatches < 100)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h",
                     $time, what, seen, wanted);
        mismatches++;
    endtask

    // updates the shadow table and returns the result the request should produce
    function automatic entry_result_t resolve_request(
        input logic [ACTION_W-1:0]      act,
        input logic [ITEM_ID_W-1:0]     id,
        input logic                     doc,
        input logic [ENTRY_INDEX_W-1:0] idx
    );
        entry_result_t res;
        int unsigned   pos;
        int unsigned   i;
        logic          present;
        logic          prior;
        logic          flipped;
        res = '0;
        if (act == ACT_TOGGLE || act == ACT_LOOKUP)
        begin
            pos = 0;
            while (pos < used_entries && entry_ids[pos] < id)
                pos++;
            present = (pos < used_entries) && (entry_ids[pos] == id);
            prior   = present ? entry_bits[pos] : doc;
            flipped = ~prior;
            if (act == ACT_LOOKUP)
            begin
                res.checked = prior;
            end
            else if (flipped == doc)
            begin
                // back to the document value: drop the override, close the gap
                if (present)
                begin
                    for (i = pos; i + 1 < used_entries; i++)
                    begin
                        entry_ids[i]  = entry_ids[i + 1];
                        entry_bits[i] = entry_bits[i + 1];
                    end
                    used_entries--;
                    n_erased++;
                end
                res.checked = flipped;
            end
            else if (present)
            begin
                entry_bits[pos] = flipped;
                res.checked     = flipped;
            end
            else if (used_entries >= SOBT_MAX_ENTRIES)
            begin
                res.status = STATUS_FULL;
                n_full++;
            end
            else
            begin
                for (i = used_entries; i > pos; i--)
                begin
                    entry_ids[i]  = entry_ids[i - 1];
                    entry_bits[i] = entry_bits[i - 1];
                end
                entry_ids[pos]  = id;
                entry_bits[pos] = flipped;
                used_entries++;
                res.checked = flipped;
            end
        end
        else if (act == ACT_READ)
        begin
            if (idx < used_entries)
            begin
                res.entry_item_id = entry_ids[idx];
                res.checked       = entry_bits[idx];
            end
            else
            begin
                res.status = STATUS_RANGE;
                n_range++;
            end
        end
        else
        begin
            used_entries = 0;
        end
        res.entry_count = ENTRY_COUNT_W'(used_entries);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        entry_result_t seen;
        entry_result_t wanted;
        if (!rst_n)
        begin
            used_entries = 0;
            awaited_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{status, checked, entry_item_id, entry_count};
                n_results++;
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("result with no request outstanding", seen, 0);
                end
                else
                begin
                    wanted = awaited_results.pop_front();
                    if (seen.status !== wanted.status)
                        report_mismatch("status", seen.status, wanted.status);
                    if (seen.checked !== wanted.checked)
                        report_mismatch("checked", seen.checked, wanted.checked);
                    if (seen.entry_item_id !== wanted.entry_item_id)
                        report_mismatch("entry_item_id", seen.entry_item_id,
                                        wanted.entry_item_id);
                    if (seen.entry_count !== wanted.entry_count)
                        report_mismatch("entry_count", seen.entry_count,
                                        wanted.entry_count);
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(resolve_request(action, item_id,
                                                          document_checked, entry_index));
        end
        fail_count    <= mismatches;
        pending       <= awaited_results.size();
        results_seen  <= n_results;
        full_refusals <= n_full;
        erasures      <= n_erased;
        range_reads   <= n_range;
    end

endmodule

// File: tb/sv/testbench.sv
// Testbench top for the sorted override bit table: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module testbench
    import sobt_pkg::*;
();

    localparam int ITEM_TARGET  = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_OFF_LEN = 300;
    localparam int HOLD_OFF_AT  = 40;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [ACTION_W-1:0]      action;
    logic [ITEM_ID_W-1:0]     item_id;
    logic                     document_checked;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic                     out_valid;
    logic                     out_stall;
    logic [STATUS_W-1:0]      status;
    logic                     checked;
    logic [ITEM_ID_W-1:0]     entry_item_id;
    logic [ENTRY_COUNT_W-1:0] entry_count;

    int fail_count;
    int pending;
    int results_seen;
    int full_refusals;
    int erasures;
    int range_reads;

    int sent_count = 0;
    int burst_left = 0;
    int cycles     = 0;

    always #5 clk = ~clk;

    sorted_override_bit_table_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .item_id          (item_id),
        .document_checked (document_checked),
        .entry_index      (entry_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .checked          (checked),
        .entry_item_id    (entry_item_id),
        .entry_count      (entry_count)
    );

    sobt_checker result_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .item_id          (item_id),
        .document_checked (document_checked),
        .entry_index      (entry_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .checked          (checked),
        .entry_item_id    (entry_item_id),
        .entry_count      (entry_count),
        .fail_count       (fail_count),
        .pending          (pending),
        .results_seen     (results_seen),
        .full_refusals    (full_refusals),
        .erasures         (erasures),
        .range_reads      (range_reads)
    );

    function automatic logic [ITEM_ID_W-1:0] rand_id();
        return ITEM_ID_W'($urandom());
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom());
    endfunction

    function automatic logic [ENTRY_INDEX_W-1:0] rand_index();
        return ENTRY_INDEX_W'($urandom());
    endfunction

    function automatic int new_burst();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    endfunction

    // id from a strided pool, now and then one of the extremes
    function automatic logic [ITEM_ID_W-1:0] pool_id(input logic [ITEM_ID_W-1:0] base,
                                                     input logic [ITEM_ID_W-1:0] stride,
                                                     input int size);
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, 1) ? '1 : '0;
        return ITEM_ID_W'(base + $urandom_range(0, size - 1) * stride);
    endfunction

    task automatic send_request(input logic [ACTION_W-1:0]      act,
                                input logic [ITEM_ID_W-1:0]     id,
                                input logic                     doc,
                                input logic [ENTRY_INDEX_W-1:0] idx);
        in_valid         <= 1'b1;
        action           <= act;
        item_id          <= id;
        document_checked <= doc;
        entry_index      <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6))
                @(posedge clk);
            burst_left = new_burst();
        end
    endtask

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("testbench failed");
        $finish;
    end

    initial
    begin : receiver
        int  mode;
        int  span;
        int  duty;
        int  hold_left;
        bit  held;
        mode      = 0;
        span      = 0;
        duty      = 2;
        hold_left = 0;
        held      = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (!held && sent_count >= HOLD_OFF_AT)
            begin
                // long hold-off so the block backs up into its input
                held      = 1;
                hold_left = HOLD_OFF_LEN - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(10, 80);
                    duty = $urandom_range(2, 5);
                end
                span--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= rand_bit();
                    default: out_stall <= (span % duty) == 0;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int                   kind;
        int                   n;
        int                   len;
        int                   k;
        int                   r;
        bit                   filled_once;
        logic [ITEM_ID_W-1:0] base;
        logic [ITEM_ID_W-1:0] stride;
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        action           <= ACT_TOGGLE;
        item_id          <= '0;
        document_checked <= 1'b0;
        entry_index      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = new_burst();

        // directed: empty table, extreme ids, update, erase, clear
        send_request(ACT_LOOKUP, 16'h0000, 1'b0, rand_index());
        send_request(ACT_READ,   rand_id(), rand_bit(), '0);
        send_request(ACT_TOGGLE, 16'h0000, 1'b0, '1);
        send_request(ACT_TOGGLE, 16'hFFFF, 1'b1, '0);
        send_request(ACT_TOGGLE, 16'h8000, 1'b0, '1);
        send_request(ACT_LOOKUP, 16'hFFFF, 1'b1, '0);
        send_request(ACT_LOOKUP, 16'h1234, 1'b1, '1);
        send_request(ACT_READ,   16'hFFFF, 1'b1, 6'd0);
        send_request(ACT_READ,   16'h0000, 1'b0, 6'd1);
        send_request(ACT_READ,   16'hFFFF, 1'b1, 6'd2);
        send_request(ACT_READ,   16'h0000, 1'b0, 6'd3);
        send_request(ACT_READ,   16'hFFFF, 1'b1, '1);
        send_request(ACT_TOGGLE, 16'h8000, 1'b1, 6'd21);
        send_request(ACT_TOGGLE, 16'h8000, 1'b1, 6'd42);
        send_request(ACT_TOGGLE, 16'h0000, 1'b0, '1);
        send_request(ACT_READ,   16'hAAAA, 1'b0, 6'd0);
        send_request(ACT_CLEAR,  16'hFFFF, 1'b1, '1);
        send_request(ACT_READ,   16'h5555, 1'b1, 6'd0);
        send_request(ACT_LOOKUP, 16'hFFFF, 1'b1, '0);
        send_request(ACT_CLEAR,  16'h0000, 1'b0, '0);

        filled_once = 0;
        while (sent_count < ITEM_TARGET)
        begin
            kind        = filled_once ? $urandom_range(0, 9) : 0;
            filled_once = 1;
            base        = rand_id();
            stride      = ITEM_ID_W'($urandom_range(0, 1023) * 2 + 1);
            if ($urandom_range(0, 1))
                stride = -stride;
            case (kind)
                0, 1, 2:
                begin
                    // fill from empty past capacity, then hit the full table
                    send_request(ACT_CLEAR, rand_id(), rand_bit(), rand_index());
                    n = $urandom_range(64, 72);
                    for (k = 0; k < n; k++)
                    begin
                        send_request(ACT_TOGGLE, ITEM_ID_W'(base + k * stride),
                                     rand_bit(), rand_index());
                        if ($urandom_range(0, 4) == 0)
                            send_request($urandom_range(0, 1) ? ACT_READ : ACT_LOOKUP,
                                         ITEM_ID_W'(base + $urandom_range(0, k) * stride),
                                         rand_bit(), rand_index());
                    end
                    for (k = 0; k < 8; k++)
                        send_request(ACT_TOGGLE,
                                     ITEM_ID_W'(base + $urandom_range(0, n + 8) * stride),
                                     rand_bit(), rand_index());
                end
                3, 4, 5, 6:
                begin
                    // churn over a small id pool
                    n   = $urandom_range(2, 100);
                    len = $urandom_range(30, 120);
                    for (k = 0; k < len; k++)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 60)
                            send_request(ACT_TOGGLE, pool_id(base, stride, n),
                                         rand_bit(), rand_index());
                        else if (r < 75)
                            send_request(ACT_LOOKUP,
                                         (r < 70) ? pool_id(base, stride, n) : rand_id(),
                                         rand_bit(), rand_index());
                        else if (r < 98)
                            send_request(ACT_READ, rand_id(), rand_bit(),
                                         $urandom_range(0, 1) ?
                                             ENTRY_INDEX_W'($urandom_range(0, 15)) :
                                             rand_index());
                        else
                            send_request(ACT_CLEAR, rand_id(), rand_bit(), rand_index());
                    end
                end
                7, 8:
                begin
                    len = $urandom_range(10, 40);
                    for (k = 0; k < len; k++)
                        send_request(ACTION_W'($urandom()), rand_id(), rand_bit(),
                                     rand_index());
                end
                default:
                begin
                    for (k = 0; k < SOBT_MAX_ENTRIES; k++)
                        send_request(ACT_READ, rand_id(), rand_bit(), ENTRY_INDEX_W'(k));
                end
            endcase
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (12) @(posedge clk);

        $display("Ran %0d requests and checked %0d results, with a long output hold-off.",
                 sent_count, results_seen);
        $display("Seen: %0d refused inserts on a full table, %0d erasures,",
                 full_refusals, erasures);
        $display("      %0d reads out of range.", range_reads);
        if (fail_count == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
